### rtl/jdq_pkg.sv
// ----------------------------------------------------------------------------
// jdq_pkg
// shared types, register map and direction codes for the direction qualifier
// ----------------------------------------------------------------------------
package jdq_pkg;

    localparam int AXIS_W   = 12;
    localparam int ZONE_W   = 11;
    localparam int DEB_W    = 16;
    localparam int STAMP_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_X_CENTER    = 2'd0;
    localparam logic [1:0] REG_Y_CENTER    = 2'd1;
    localparam logic [1:0] REG_DEAD_ZONE   = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE_MS = 2'd3;

    localparam logic [AXIS_W-1:0] X_CENTER_RST    = 12'd2048;
    localparam logic [AXIS_W-1:0] Y_CENTER_RST    = 12'd2048;
    localparam logic [ZONE_W-1:0] DEAD_ZONE_RST   = 11'd500;
    localparam logic [DEB_W-1:0]  DEBOUNCE_MS_RST = 16'd50;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4,
        DIR_PRESS = 3'd5
    } dir_t;

    typedef struct packed {
        logic [AXIS_W-1:0]  x_sample;
        logic [AXIS_W-1:0]  y_sample;
        logic               button_level;
        logic [STAMP_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        dir_t               direction;
        logic               button_held;
        logic               button_new_press;
        logic [STAMP_W-1:0] last_action_ms;
    } out_t;

    typedef struct packed {
        logic [AXIS_W-1:0] x_center;
        logic [AXIS_W-1:0] y_center;
        logic [ZONE_W-1:0] dead_zone;
        logic [DEB_W-1:0]  debounce_ms;
    } cfg_t;

    // classifier status toward the state update
    typedef struct packed {
        dir_t dir;
        logic center;
    } cls_t;

endpackage

### rtl/jdq_regs.sv
// ----------------------------------------------------------------------------
// jdq_regs
// apb-style configuration registers: centers, dead zone, debounce time
// ----------------------------------------------------------------------------
module jdq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jdq_pkg::PADDR_W-1:0]   paddr,
    input  logic [jdq_pkg::PDATA_W-1:0]   pwdata,
    output logic [jdq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output jdq_pkg::cfg_t                 cfg
);
    import jdq_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_X_CENTER:    cfg_next.x_center    = pwdata[AXIS_W-1:0];
                REG_Y_CENTER:    cfg_next.y_center    = pwdata[AXIS_W-1:0];
                REG_DEAD_ZONE:   cfg_next.dead_zone   = pwdata[ZONE_W-1:0];
                REG_DEBOUNCE_MS: cfg_next.debounce_ms = pwdata[DEB_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_center    <= X_CENTER_RST;
            cfg_reg.y_center    <= Y_CENTER_RST;
            cfg_reg.dead_zone   <= DEAD_ZONE_RST;
            cfg_reg.debounce_ms <= DEBOUNCE_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_X_CENTER:    prdata = {{(PDATA_W-AXIS_W){1'b0}}, cfg_reg.x_center};
            REG_Y_CENTER:    prdata = {{(PDATA_W-AXIS_W){1'b0}}, cfg_reg.y_center};
            REG_DEAD_ZONE:   prdata = {{(PDATA_W-ZONE_W){1'b0}}, cfg_reg.dead_zone};
            REG_DEBOUNCE_MS: prdata = {{(PDATA_W-DEB_W){1'b0}}, cfg_reg.debounce_ms};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/jdq_classify.sv
// ----------------------------------------------------------------------------
// jdq_classify
// stick direction outside the dead zone and the half-zone center test
// ----------------------------------------------------------------------------
module jdq_classify (
    input  jdq_pkg::in_t  item,
    input  jdq_pkg::cfg_t cfg,
    output jdq_pkg::cls_t cls
);
    import jdq_pkg::*;

    logic signed [AXIS_W+1:0] x_s;
    logic signed [AXIS_W+1:0] y_s;
    logic signed [AXIS_W+1:0] x_lo;
    logic signed [AXIS_W+1:0] x_hi;
    logic signed [AXIS_W+1:0] y_lo;
    logic signed [AXIS_W+1:0] y_hi;
    logic signed [AXIS_W:0]   dx;
    logic signed [AXIS_W:0]   dy;
    logic        [AXIS_W:0]   ax;
    logic        [AXIS_W:0]   ay;
    logic        [AXIS_W:0]   half;
    dir_t                     nd;

    always_comb
    begin
        // all thresholds two bits wider than the axis so nothing wraps
        x_s  = $signed({2'b00, item.x_sample});
        y_s  = $signed({2'b00, item.y_sample});
        x_lo = $signed({2'b00, cfg.x_center}) - $signed({3'b000, cfg.dead_zone});
        x_hi = $signed({2'b00, cfg.x_center}) + $signed({3'b000, cfg.dead_zone});
        y_lo = $signed({2'b00, cfg.y_center}) - $signed({3'b000, cfg.dead_zone});
        y_hi = $signed({2'b00, cfg.y_center}) + $signed({3'b000, cfg.dead_zone});

        // x has priority over y
        if (x_s < x_lo)
            nd = DIR_LEFT;
        else if (x_s > x_hi)
            nd = DIR_RIGHT;
        else if (y_s < y_lo)
            nd = DIR_DOWN;
        else if (y_s > y_hi)
            nd = DIR_UP;
        else
            nd = DIR_NONE;

        dx   = $signed({1'b0, item.x_sample}) - $signed({1'b0, cfg.x_center});
        dy   = $signed({1'b0, item.y_sample}) - $signed({1'b0, cfg.y_center});
        ax   = dx[AXIS_W] ? $unsigned(-dx) : $unsigned(dx);
        ay   = dy[AXIS_W] ? $unsigned(-dy) : $unsigned(dy);
        half = {3'b000, cfg.dead_zone[ZONE_W-1:1]};

        cls.dir    = nd;
        cls.center = (nd == DIR_NONE) && (ax < half) && (ay < half);
    end

endmodule

### rtl/jdq_state.sv
// ----------------------------------------------------------------------------
// jdq_state
// debounce, direction acceptance and held-direction state, one item per advance
// ----------------------------------------------------------------------------
module jdq_state (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  jdq_pkg::in_t  item,
    input  jdq_pkg::cfg_t cfg,
    input  jdq_pkg::cls_t cls,
    output jdq_pkg::out_t result
);
    import jdq_pkg::*;

    logic               stable_reg;
    logic               stable_next;
    logic               raw_prev_reg;
    logic [STAMP_W-1:0] change_stamp_reg;
    logic [STAMP_W-1:0] change_stamp_next;
    logic [STAMP_W-1:0] action_stamp_reg;
    logic [STAMP_W-1:0] action_stamp_next;
    dir_t               prev_dir_reg;
    dir_t               prev_dir_next;
    dir_t               held_dir_reg;
    dir_t               held_dir_next;

    logic [STAMP_W-1:0] stamp_a;
    logic [STAMP_W-1:0] elapsed;
    logic               settle;
    logic               press_now;
    dir_t               held_a;
    dir_t               held_b;
    dir_t               prev_b;
    logic [STAMP_W-1:0] action_a;
    logic               consider;
    logic               same_dir;
    logic               take_dir;

    always_comb
    begin
        // button debounce shares change stamp with the repeat timer
        stamp_a   = (item.button_level != raw_prev_reg) ? item.now_ms : change_stamp_reg;
        elapsed   = item.now_ms - stamp_a;
        settle    = (elapsed > {{(STAMP_W-DEB_W){1'b0}}, cfg.debounce_ms})
                    && (item.button_level != stable_reg);
        stable_next = settle ? item.button_level : stable_reg;
        press_now = settle && !item.button_level;
        held_a    = press_now ? DIR_PRESS : held_dir_reg;
        action_a  = press_now ? item.now_ms : action_stamp_reg;

        // new direction at once, repeat after twice the debounce time
        consider  = (held_a != DIR_PRESS) && (cls.dir != DIR_NONE);
        same_dir  = (cls.dir == prev_dir_reg);
        take_dir  = consider && (!same_dir ||
                    (elapsed > {{(STAMP_W-DEB_W-1){1'b0}}, cfg.debounce_ms, 1'b0}));
        prev_b    = (consider && !same_dir) ? cls.dir : prev_dir_reg;
        change_stamp_next = (consider && !same_dir) ? item.now_ms : stamp_a;
        held_b    = take_dir ? cls.dir : held_a;
        action_stamp_next = take_dir ? item.now_ms : action_a;

        // only the center zone clears
        prev_dir_next = cls.center ? DIR_NONE : prev_b;
        held_dir_next = cls.center ? DIR_NONE : held_b;

        result.direction        = held_dir_next;
        result.button_held      = !stable_next;
        result.button_new_press = !stable_next && item.button_level;
        result.last_action_ms   = action_stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg       <= 1'b0;
            raw_prev_reg     <= 1'b0;
            change_stamp_reg <= '0;
            action_stamp_reg <= '0;
            prev_dir_reg     <= DIR_NONE;
            held_dir_reg     <= DIR_NONE;
        end
        else if (advance)
        begin
            stable_reg       <= stable_next;
            raw_prev_reg     <= item.button_level;
            change_stamp_reg <= change_stamp_next;
            action_stamp_reg <= action_stamp_next;
            prev_dir_reg     <= prev_dir_next;
            held_dir_reg     <= held_dir_next;
        end
    end

`ifndef SYNTHESIS
    // state only moves with an item
    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(held_dir_reg) && $stable(change_stamp_reg))
        else $error("state changed without an item");

    // press is held until the center clears it
    a_press_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (held_dir_reg == DIR_PRESS) && !cls.center
        |=> held_dir_reg == DIR_PRESS)
        else $error("press released outside center zone");

    // a held direction other than none was also recorded as previous or is press
    a_prev_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance && take_dir && !cls.center |=> held_dir_reg == prev_dir_reg)
        else $error("accepted direction not recorded");
`endif

endmodule

### rtl/joystick_direction_qualifier.sv
// ----------------------------------------------------------------------------
// joystick_direction_qualifier: debounced button and dead-zone stick direction
// path from sample request to result request: input reg, per-item logic, result reg
// throughput 1 request per cycle unless a stalled full result reg holds it back
// reset: async active low, config to defaults, debounce and direction state cleared
// ----------------------------------------------------------------------------
module joystick_direction_qualifier (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  jdq_pkg::in_t                  sample,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output jdq_pkg::out_t                 result,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jdq_pkg::PADDR_W-1:0]   paddr,
    input  logic [jdq_pkg::PDATA_W-1:0]   pwdata,
    output logic [jdq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import jdq_pkg::*;

    cfg_t cfg;
    cls_t cls;
    out_t result_next;

    // input register holds one request
    in_t  in_reg;
    logic in_valid_reg;
    logic in_valid_next;

    // result register
    out_t out_reg;
    logic out_valid_reg;
    logic out_valid_next;

    logic in_take;
    logic advance;

    // the held item moves on when the result register is free or being drained
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    // stall only while the input register is full and cannot move on
    assign sample_stall = in_valid_reg && !advance;
    assign in_take      = sample_valid && !sample_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= sample;
        if (advance)
            out_reg <= result_next;
    end

    jdq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // direction from the registered sample
    jdq_classify u_classify (
        .item (in_reg),
        .cfg  (cfg),
        .cls  (cls)
    );

    // debounce and acceptance state, updated as the item moves to the result reg
    jdq_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .cls     (cls),
        .result  (result_next)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // stall only with a full input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> in_valid_reg)
        else $error("sample stalled with empty input register");

    // a held request is never dropped
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("held sample request lost");

    // every moved item shows up as a result
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("result missing after advance");

    // a new press is always a held press
    a_new_press: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.button_new_press |-> result.button_held)
        else $error("new press without held button");
`endif

endmodule

### dv/joystick_direction_qualifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_direction_qualifier_tb
// self-checking bench for the debounced button and dead-zone stick qualifier:
// a directed table and then random sample streams under several register
// settings, with random gaps and stalls on both channels and every result checked
// against its typed row or an in-bench model of the debounce and direction logic
// ----------------------------------------------------------------------------
module joystick_direction_qualifier_tb;
    import jdq_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 4;     // input reg, result reg, margin
    localparam int N_DIRECTED      = 25;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 125;

    // one row of the directed table; want is only used where typed is set
    typedef struct packed {
        in_t  req;
        logic typed;
        out_t want;
    } stick_row_t;

    localparam out_t NO_WANT = '{DIR_NONE, 1'b0, 1'b0, 32'd0};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    in_t                  sample;
    logic                 result_valid;
    logic                 result_stall;
    out_t                 result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // model of the block: register copy and debounce / direction state
    cfg_t                 stick_cfg  = '{X_CENTER_RST, Y_CENTER_RST, DEAD_ZONE_RST,
                                         DEBOUNCE_MS_RST};
    logic                 stable_lvl = 1'b0;
    logic                 raw_lvl    = 1'b0;
    logic [STAMP_W-1:0]   change_ms  = '0;
    logic [STAMP_W-1:0]   action_ms  = '0;
    dir_t                 prev_dir   = DIR_NONE;
    dir_t                 held_dir   = DIR_NONE;

    // results predicted for accepted samples, oldest first
    out_t                 qualified_results[$];
    int                   mismatches  = 0;
    int                   cycle_count = 0;
    // when set both sides run back to back with no idling
    logic                 steady_run  = 1'b0;

    // directed table: reset state, debounce edges, press hold, zone
    // boundaries, axis priority, half-zone clearing and time wrap
    stick_row_t directed_rows [N_DIRECTED] = '{
        // after reset the button reads as held, center clears nothing
        '{'{12'd2048, 12'd2048, 1'b0, 32'd0},   1'b1, '{DIR_NONE, 1'b1, 1'b0, 32'd0}},
        // raw release, not settled yet: held plus new-press flag
        '{'{12'd2048, 12'd2048, 1'b1, 32'd10},  1'b1, '{DIR_NONE, 1'b1, 1'b1, 32'd0}},
        // one past the settle time: released
        '{'{12'd2048, 12'd2048, 1'b1, 32'd61},  1'b1, '{DIR_NONE, 1'b0, 1'b0, 32'd0}},
        '{'{12'd2048, 12'd2048, 1'b0, 32'd100}, 1'b1, '{DIR_NONE, 1'b0, 1'b0, 32'd0}},
        // settled press at center, cleared at once by the center zone
        '{'{12'd2048, 12'd2048, 1'b0, 32'd151}, 1'b0, NO_WANT},
        '{'{12'd4095, 12'd2048, 1'b0, 32'd160}, 1'b0, NO_WANT},
        '{'{12'd0,    12'd2048, 1'b1, 32'd200}, 1'b0, NO_WANT},
        // same direction before twice the settle time: no repeat; past it: repeat
        '{'{12'd0,    12'd2048, 1'b1, 32'd251}, 1'b0, NO_WANT},
        '{'{12'd0,    12'd2048, 1'b1, 32'd301}, 1'b0, NO_WANT},
        '{'{12'd0,    12'd2048, 1'b0, 32'd310}, 1'b0, NO_WANT},
        // press settles while the stick is off center and then holds
        '{'{12'd0,    12'd2048, 1'b0, 32'd361}, 1'b0, NO_WANT},
        '{'{12'd4095, 12'd2048, 1'b0, 32'd400}, 1'b0, NO_WANT},
        '{'{12'd2048, 12'd2048, 1'b0, 32'd410}, 1'b0, NO_WANT},
        // exactly on and one past the dead-zone edges
        '{'{12'd1548, 12'd2048, 1'b0, 32'd420}, 1'b0, NO_WANT},
        '{'{12'd1547, 12'd2048, 1'b0, 32'd430}, 1'b0, NO_WANT},
        '{'{12'd2548, 12'd2048, 1'b0, 32'd440}, 1'b0, NO_WANT},
        // x wins over y
        '{'{12'd2549, 12'd0,    1'b0, 32'd450}, 1'b0, NO_WANT},
        '{'{12'd2048, 12'd0,    1'b0, 32'd460}, 1'b0, NO_WANT},
        '{'{12'd2048, 12'd4095, 1'b0, 32'd470}, 1'b0, NO_WANT},
        // just inside and exactly on the half-zone edge
        '{'{12'd2297, 12'd2048, 1'b0, 32'd480}, 1'b0, NO_WANT},
        '{'{12'd2048, 12'd1798, 1'b0, 32'd490}, 1'b0, NO_WANT},
        // timestamps across the wrap and running backward
        '{'{12'd2048, 12'd4095, 1'b1, 32'hFFFF_FFF0}, 1'b0, NO_WANT},
        '{'{12'd2048, 12'd4095, 1'b1, 32'h0000_0050}, 1'b0, NO_WANT},
        '{'{12'd4095, 12'd4095, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
        '{'{12'd0,    12'd0,    1'b0, 32'd0},         1'b0, NO_WANT}
    };

    joystick_direction_qualifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("joystick_direction_qualifier verification failed");
            $finish;
        end
    end

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endfunction

    // advance the model by one sample and return the result it gives
    function automatic out_t qualify_sample(in_t s);
        int                 x;
        int                 y;
        int                 xc;
        int                 yc;
        int                 th;
        logic [STAMP_W-1:0] settle_ms;
        logic [STAMP_W-1:0] repeat_ms;
        dir_t               nd;
        out_t               r;
        x         = int'(s.x_sample);
        y         = int'(s.y_sample);
        xc        = int'(stick_cfg.x_center);
        yc        = int'(stick_cfg.y_center);
        th        = int'(stick_cfg.dead_zone);
        settle_ms = {16'd0, stick_cfg.debounce_ms};
        repeat_ms = {15'd0, stick_cfg.debounce_ms, 1'b0};
        nd        = DIR_NONE;

        // button debounce, stamp shared with direction repeat
        if (s.button_level != raw_lvl)
            change_ms = s.now_ms;
        if ((s.now_ms - change_ms) > settle_ms && s.button_level != stable_lvl)
        begin
            stable_lvl = s.button_level;
            if (!stable_lvl)
            begin
                held_dir  = DIR_PRESS;
                action_ms = s.now_ms;
            end
        end
        raw_lvl = s.button_level;

        // x axis first
        if (x < xc - th)
            nd = DIR_LEFT;
        else if (x > xc + th)
            nd = DIR_RIGHT;
        else if (y < yc - th)
            nd = DIR_DOWN;
        else if (y > yc + th)
            nd = DIR_UP;

        // a press blocks any stick direction until the center clears it
        if (held_dir != DIR_PRESS && nd != DIR_NONE)
        begin
            if (nd != prev_dir)
            begin
                prev_dir  = nd;
                change_ms = s.now_ms;
                held_dir  = nd;
                action_ms = s.now_ms;
            end
            else if ((s.now_ms - change_ms) > repeat_ms)
            begin
                held_dir  = nd;
                action_ms = s.now_ms;
            end
        end

        // both axes strictly inside half the dead zone
        if (nd == DIR_NONE && (x > xc ? x - xc : xc - x) < th / 2
                && (y > yc ? y - yc : yc - y) < th / 2)
        begin
            prev_dir = DIR_NONE;
            held_dir = DIR_NONE;
        end

        r.direction        = held_dir;
        r.button_held      = !stable_lvl;
        r.button_new_press = !stable_lvl && raw_lvl;
        r.last_action_ms   = action_ms;
        return r;
    endfunction

    // one axis reading: near the center, around a zone edge or anywhere
    function automatic logic [AXIS_W-1:0] axis_pick(int c, int th, logic near);
        int v;
        if (near)
            v = c - th / 2 + int'($urandom_range(0, th));
        else
            case ($urandom_range(0, 4))
                0:       v = c - th - 2 + int'($urandom_range(0, 4));
                1:       v = c + th - 2 + int'($urandom_range(0, 4));
                2:       v = 0;
                3:       v = 4095;
                default: v = int'($urandom_range(0, 4095));
            endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[AXIS_W-1:0];
    endfunction

    // present one sample after a random gap and log its prediction on accept
    task automatic offer_sample(in_t s, logic typed, out_t want);
        int   gap;
        out_t predicted;
        gap = steady_run ? 0 : int'($urandom_range(0, 19));
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        predicted = qualify_sample(s);
        qualified_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // let every pending result drain, then let the pipeline settle
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (qualified_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // apb write, then read back and compare the register's bits
    task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] readback;
        case (idx)
            REG_X_CENTER:    mask = 32'h0000_0FFF;
            REG_Y_CENTER:    mask = 32'h0000_0FFF;
            REG_DEAD_ZONE:   mask = 32'h0000_07FF;
            default:         mask = 32'h0000_FFFF;
        endcase
        // setup then access phase of the write
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        // read back on the same address
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;

        case (idx)
            REG_X_CENTER:    stick_cfg.x_center    = value[AXIS_W-1:0];
            REG_Y_CENTER:    stick_cfg.y_center    = value[AXIS_W-1:0];
            REG_DEAD_ZONE:   stick_cfg.dead_zone   = value[ZONE_W-1:0];
            default:         stick_cfg.debounce_ms = value[DEB_W-1:0];
        endcase
        if ((readback & mask) !== (value & mask))
            note_mismatch($sformatf("register %0d readback expected %h got %h",
                                    idx, value & mask, readback & mask));
    endtask

    // result side: random stall per result, check each accepted result
    initial
    begin : result_sink
        int   hold;
        out_t want;
        @(posedge rst_n);
        forever
        begin
            hold = steady_run ? 0 : int'($urandom_range(0, 19));
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            if (qualified_results.size() == 0)
                note_mismatch("result with no sample pending");
            else
            begin
                want = qualified_results.pop_front();
                if (result.direction !== want.direction
                        || result.button_held !== want.button_held
                        || result.button_new_press !== want.button_new_press
                        || result.last_action_ms !== want.last_action_ms)
                    note_mismatch($sformatf(
                        "dir/held/new/stamp expected %0d/%b/%b/%h got %0d/%b/%b/%h",
                        want.direction, want.button_held, want.button_new_press,
                        want.last_action_ms, result.direction, result.button_held,
                        result.button_new_press, result.last_action_ms));
            end
            @(negedge clk);
        end
    end

    // main sequence: reset, directed table, register phases with random streams
    initial
    begin : stimulus
        cfg_t               phase_cfg [N_PHASES];
        in_t                s;
        logic [STAMP_W-1:0] stamp_now;
        logic               btn_level;
        logic [AXIS_W-1:0]  stick_x;
        logic [AXIS_W-1:0]  stick_y;
        logic               near;
        int                 deb;

        // every input known from time zero
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        stamp_now    = '0;
        btn_level    = 1'b1;
        stick_x      = 12'd2048;
        stick_y      = 12'd2048;

        // defaults, all-zero, all-max, tiny zone, offset centers, then random
        phase_cfg[0] = '{12'd2048, 12'd2048, 11'd500,  16'd50};
        phase_cfg[1] = '{12'd0,    12'd0,    11'd0,    16'd0};
        phase_cfg[2] = '{12'd4095, 12'd4095, 11'd2047, 16'd65535};
        phase_cfg[3] = '{12'd2048, 12'd2048, 11'd1,    16'd1};
        phase_cfg[4] = '{12'd1000, 12'd3000, 11'd100,  16'd5};
        for (int p = 5; p < N_PHASES; p++)
            phase_cfg[p] = '{AXIS_W'($urandom_range(0, 4095)), AXIS_W'($urandom_range(0, 4095)),
                             ZONE_W'($urandom_range(0, 2047)), DEB_W'($urandom_range(0, 300))};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at reset settings
        foreach (directed_rows[i])
            offer_sample(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_register(REG_X_CENTER,    {20'd0, phase_cfg[p].x_center});
            write_register(REG_Y_CENTER,    {20'd0, phase_cfg[p].y_center});
            write_register(REG_DEAD_ZONE,   {21'd0, phase_cfg[p].dead_zone});
            write_register(REG_DEBOUNCE_MS, {16'd0, phase_cfg[p].debounce_ms});
            deb = int'(stick_cfg.debounce_ms);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // stretches with no idling on either side
                if ($urandom_range(0, 39) == 0)
                    steady_run = !steady_run;

                if ($urandom_range(0, 15) == 0)
                begin
                    // noise: every field random
                    s.x_sample     = AXIS_W'($urandom_range(0, 4095));
                    s.y_sample     = AXIS_W'($urandom_range(0, 4095));
                    s.button_level = 1'($urandom_range(0, 1));
                    s.now_ms       = $urandom;
                    stamp_now      = s.now_ms;
                end
                else
                begin
                    // time mostly moves forward around the settle and repeat windows
                    case ($urandom_range(0, 7))
                        0:       stamp_now = stamp_now + $urandom_range(0, 3);
                        1:       stamp_now = $urandom;
                        default: stamp_now = stamp_now + $urandom_range(0, 2 * deb + 4);
                    endcase
                    // button held in runs with occasional toggles
                    if ($urandom_range(0, 7) == 0)
                        btn_level = !btn_level;
                    // stick often stays put so repeats get exercised
                    if ($urandom_range(0, 1) == 0)
                    begin
                        near    = ($urandom_range(0, 3) == 0);
                        stick_x = axis_pick(int'(stick_cfg.x_center),
                                            int'(stick_cfg.dead_zone), near);
                        stick_y = axis_pick(int'(stick_cfg.y_center),
                                            int'(stick_cfg.dead_zone), near);
                    end
                    s.x_sample     = stick_x;
                    s.y_sample     = stick_y;
                    s.button_level = btn_level;
                    s.now_ms       = stamp_now;
                end
                offer_sample(s, 1'b0, NO_WANT);
            end
            drain_results();
        end

        if (mismatches == 0 && qualified_results.size() == 0)
            $display("joystick_direction_qualifier verification clean");
        else
            $display("joystick_direction_qualifier verification failed");
        $finish;
    end

endmodule
